[rtl/core/pto_pkg.sv]
// Package for the periodic timer with overrun count.
// Types, widths and codes shared by the timer core and its divider. No dependencies.
`default_nettype none

package pto_pkg;

	localparam int TIME_W  = 63;
	localparam int COUNT_W = 32;
	localparam int KIND_W  = 2;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef logic [TIME_W-1:0]  time_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_SCHED = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_FIRE
	} state_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic   done;
		count_t quot;
		time_t  rem;
	} div_res_t;

endpackage

`default_nettype wire

[rtl/core/pto_in_if.sv]
// Request channel of the periodic timer: valid/ready plus one timer request.
// Depends on pto_pkg for widths.
`default_nettype none

interface pto_in_if;
	import pto_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	time_t               now_us;
	logic                is_absolute;
	time_t               deadline_us;
	time_t               period_us;

	modport source (
		output valid, kind, now_us, is_absolute, deadline_us, period_us,
		input  ready
	);
	modport sink (
		input  valid, kind, now_us, is_absolute, deadline_us, period_us,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/pto_out_if.sv]
// Response channel of the periodic timer: valid/ready plus one timer response.
// Depends on pto_pkg for widths.
`default_nettype none

interface pto_out_if;
	import pto_pkg::*;

	logic   valid;
	logic   ready;
	logic   fired;
	count_t overrun_value;
	logic   armed;

	modport source (
		output valid, fired, overrun_value, armed,
		input  ready
	);
	modport sink (
		input  valid, fired, overrun_value, armed,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/pto_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Keeps the full remainder and the low COUNT_W quotient bits. Depends on pto_pkg.
`default_nettype none

module pto_div (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  pto_pkg::time_t     dividend,
	input  pto_pkg::time_t     divisor,
	output pto_pkg::div_res_t  res
);
	import pto_pkg::*;

	localparam int CNT_W = $clog2(TIME_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(TIME_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	time_t            rem_q;
	time_t            dvd_q;
	time_t            dvs_q;
	count_t           quo_q;

	logic [TIME_W:0]  trial;
	logic [TIME_W:0]  diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, dvd_q[TIME_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits TIME_W bits
			rem_q <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			quo_q <= {quo_q[COUNT_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

`default_nettype wire

[rtl/core/periodic_timer_with_overrun.sv]
// Periodic / one-shot deadline timer with overrun count: sequencer, shared adder, state.
// Depends on pto_pkg, pto_in_if, pto_out_if and pto_div.
//
//  channel | dir | handshake   | contents
//  req     | in  | valid/ready | kind, now_us, is_absolute, deadline_us, period_us
//  rsp     | out | valid/ready | fired, overrun_value, armed
//
// One request at a time. Schedule, read, unused kinds and a tick on a disarmed timer end in S_EXEC,
// a tick without catch-up goes on to S_FIRE, a late periodic tick to S_DIV and then S_FIRE: the catch-up
// divides lateness by the period in pto_div, one quotient bit per cycle (63 steps).
// Reset clears the deadline, period and overrun count (timer disarmed).
// A held response blocks new requests only until rsp.ready takes it.
`default_nettype none

module periodic_timer_with_overrun (
	input  wire       clk,
	input  wire       arst_n,
	pto_in_if.sink    req,
	pto_out_if.source rsp
);
	import pto_pkg::*;

	state_t    state_q, state_d;

	// request held for the duration of the operation
	logic [KIND_W-1:0] kind_q;
	time_t             now_q;
	logic              abs_q;
	time_t             dl_in_q;
	time_t             per_in_q;

	// timer state
	time_t     deadline_q;
	time_t     period_q;
	count_t    count_q;
	logic      fire_q;

	// response register
	logic      out_valid_q;
	logic      out_fired_q;
	count_t    out_ovr_q;
	logic      out_armed_q;

	// shared adder
	time_t          alu_a, alu_b;
	logic           alu_sub;
	logic [TIME_W:0] alu_sum;
	time_t          alu_sat;

	logic      accept;
	logic      div_start;
	div_res_t  div_res;

	logic      fin;
	logic      dl_wr;
	time_t     dl_new;
	logic      per_wr;
	logic      cnt_wr;
	count_t    cnt_new;
	logic      o_fired;
	count_t    o_ovr;

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	always_comb begin
		alu_sum = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
			+ {{TIME_W{1'b0}}, alu_sub};
		alu_sat = alu_sum[TIME_W] ? TIME_MAX : alu_sum[TIME_W-1:0];
	end

	pto_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (alu_sum[TIME_W-1:0]),
		.divisor  (period_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		alu_a     = now_q;
		alu_b     = deadline_q;
		alu_sub   = 1'b1;
		div_start = 1'b0;
		fin       = 1'b0;
		dl_wr     = 1'b0;
		dl_new    = deadline_q;
		per_wr    = 1'b0;
		cnt_wr    = 1'b0;
		cnt_new   = count_q;
		o_fired   = 1'b0;
		o_ovr     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (kind_q)
					KIND_TICK: begin
						// alu: now - deadline, top bit is the borrow
						if (deadline_q == '0) begin
							fin     = 1'b1;
							state_d = S_IDLE;
						end else if (period_q != '0 && !alu_sum[TIME_W]
								&& alu_sum[TIME_W-1:0] != '0) begin
							div_start = 1'b1;
							state_d   = S_DIV;
						end else begin
							state_d = S_FIRE;
						end
					end
					KIND_SCHED: begin
						alu_a   = dl_in_q;
						alu_b   = now_q;
						alu_sub = 1'b0;
						fin     = 1'b1;
						dl_wr   = 1'b1;
						per_wr  = 1'b1;
						dl_new  = (dl_in_q == '0) ? '0 : (abs_q ? dl_in_q : alu_sat);
						state_d = S_IDLE;
					end
					KIND_READ: begin
						fin     = 1'b1;
						o_ovr   = count_q;
						cnt_wr  = 1'b1;
						cnt_new = '0;
						state_d = S_IDLE;
					end
					default: begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_DIV: begin
				// deadline + misses*period == now - remainder
				alu_b = div_res.rem;
				if (div_res.done) begin
					dl_wr   = 1'b1;
					dl_new  = alu_sum[TIME_W-1:0];
					cnt_wr  = 1'b1;
					cnt_new = count_q + div_res.quot;
					state_d = S_FIRE;
				end
			end
			S_FIRE: begin
				alu_a   = deadline_q;
				alu_b   = period_q;
				alu_sub = 1'b0;
				fin     = 1'b1;
				o_fired = fire_q;
				if (fire_q) begin
					dl_wr  = 1'b1;
					dl_new = (period_q == '0) ? '0 : alu_sat;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= req.kind;
			now_q    <= req.now_us;
			abs_q    <= req.is_absolute;
			dl_in_q  <= req.deadline_us;
			per_in_q <= req.period_us;
		end
		if (fin) begin
			out_fired_q <= o_fired;
			out_ovr_q   <= o_ovr;
			out_armed_q <= dl_new != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_q  <= '0;
			period_q    <= '0;
			count_q     <= '0;
			fire_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (dl_wr) begin
				deadline_q <= dl_new;
			end
			if (per_wr) begin
				period_q <= (dl_in_q == '0) ? '0 : per_in_q;
			end
			if (cnt_wr) begin
				count_q <= cnt_new;
			end
			if (state_q == S_EXEC) begin
				fire_q <= !alu_sum[TIME_W];
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.fired         = out_fired_q;
	assign rsp.overrun_value = out_ovr_q;
	assign rsp.armed         = out_armed_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted request did not start execution");

	a_div_periodic: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> period_q != '0)
		else $error("catch-up division with zero period");

	a_fire_armed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIRE |-> deadline_q != '0)
		else $error("fire check on a disarmed timer");

	a_fire_no_ovr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.fired |-> rsp.overrun_value == '0)
		else $error("fired response carries an overrun value");

endmodule

`default_nettype wire
